// ----- rtl/core/sccr_pkg.sv -----
package sccr_pkg;

   // Field widths fixed by the interface.
   localparam int KIND_W   = 2;
   localparam int SECTOR_W = 32;
   localparam int ENTRY_W  = 6;

   // Default cache size.
   localparam int ENTRIES_DEFAULT = 64;

   // Request kinds.
   localparam logic [KIND_W-1:0] KIND_READ   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FLUSH  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;        // capture the request and clear the first-invalid-entry record
      logic idx_clr;     // restart the scan index at entry zero
      logic idx_inc;     // advance the scan index
      logic note_inv;    // remember the scan index if it is the first invalid entry
      logic rd_idx;      // read the tag at the scan index
      logic rd_vic;      // read the tag at the chosen entry
      logic set_hit;     // the scan index is the hit entry
      logic pick_inv;    // the first invalid entry is the victim
      logic pick_hand;   // the entry under the hand is the victim
      logic hand_step;   // clear the reference bit under the hand and advance
      logic emit_hit;    // report a hit and update its bits
      logic emit_miss;   // report a miss, install the new tag
      logic emit_empty;  // report a flush that found nothing dirty
      logic emit_flush;  // report one dirty entry and clean it
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic idx_valid;   // entry at the scan index is valid
      logic idx_vd;      // entry at the scan index is valid and dirty
      logic idx_last;    // scan index is the final entry
      logic tag_match;   // tag read back equals the requested sector
      logic inv_found;   // an invalid entry was seen during the scan
      logic hand_ref;    // reference bit under the hand is set
      logic any_vd;      // some entry is valid and dirty
      logic more_vd;     // a valid dirty entry other than the scan index exists
   } status_type;

endpackage

// ----- rtl/core/sccr_ram.sv -----
module sccr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/sccr_datapath.sv -----
module sccr_datapath #(
   parameter int ENTRIES = sccr_pkg::ENTRIES_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  sccr_pkg::cmd_type              cmd,
   output sccr_pkg::status_type           status,
   input  logic [sccr_pkg::KIND_W-1:0]    req_kind,
   input  logic [sccr_pkg::SECTOR_W-1:0]  req_sector,
   output logic                           rsp_strobe,
   output logic                           rsp_hit,
   output logic [sccr_pkg::ENTRY_W-1:0]   rsp_entry,
   output logic                           rsp_fill_needed,
   output logic                           rsp_writeback_valid,
   output logic [sccr_pkg::SECTOR_W-1:0]  rsp_writeback_sector,
   output logic                           rsp_last
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

   logic [ENTRIES-1:0]            valid_ff, valid_in;
   logic [ENTRIES-1:0]            dirty_ff, dirty_in;
   logic [ENTRIES-1:0]            ref_ff, ref_in;
   logic [IDX_W-1:0]              idx_ff, idx_in;
   logic [IDX_W-1:0]              vic_ff, vic_in;
   logic [IDX_W-1:0]              inv_idx_ff, inv_idx_in;
   logic                          inv_found_ff, inv_found_in;
   logic [IDX_W-1:0]              hand_ff, hand_in;
   logic                          is_write_ff, is_write_in;
   logic [sccr_pkg::SECTOR_W-1:0] sector_ff, sector_in;

   logic                          strobe_ff, strobe_in;
   logic                          hit_ff, hit_in;
   logic [sccr_pkg::ENTRY_W-1:0]  entry_ff, entry_in;
   logic                          fill_ff, fill_in;
   logic                          wbv_ff, wbv_in;
   logic [sccr_pkg::SECTOR_W-1:0] wbs_ff, wbs_in;
   logic                          last_ff, last_in;

   logic                          ram_wr_en;
   logic                          ram_rd_en;
   logic [IDX_W-1:0]              ram_rd_addr;
   logic [sccr_pkg::SECTOR_W-1:0] ram_rd_data;
   logic [ENTRIES-1:0]            vd;
   logic [ENTRIES-1:0]            idx_onehot;
   logic                          vic_vd;

   // Tag store, read one entry at a time.
   sccr_ram #(
      .WIDTH(sccr_pkg::SECTOR_W),
      .DEPTH(ENTRIES)
   ) u_tags (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(vic_ff),
      .wr_data(sector_ff),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign ram_wr_en   = cmd.emit_miss;
   assign ram_rd_en   = cmd.rd_idx | cmd.rd_vic;
   assign ram_rd_addr = cmd.rd_vic ? vic_ff : idx_ff;

   // Status toward the controller.
   assign vd         = valid_ff & dirty_ff;
   assign idx_onehot = ENTRIES'(1) << idx_ff;
   assign vic_vd     = vd[vic_ff];

   always_comb begin
      status.idx_valid = valid_ff[idx_ff];
      status.idx_vd    = vd[idx_ff];
      status.idx_last  = (idx_ff == IDX_LAST);
      status.tag_match = (ram_rd_data == sector_ff);
      status.inv_found = inv_found_ff;
      status.hand_ref  = ref_ff[hand_ff];
      status.any_vd    = |vd;
      status.more_vd   = |(vd & ~idx_onehot);
   end

   // Scan, victim and policy state updates.
   always_comb begin
      logic [IDX_W+sccr_pkg::ENTRY_W-1:0] wide;
      valid_in     = valid_ff;
      dirty_in     = dirty_ff;
      ref_in       = ref_ff;
      idx_in       = idx_ff;
      vic_in       = vic_ff;
      inv_idx_in   = inv_idx_ff;
      inv_found_in = inv_found_ff;
      hand_in      = hand_ff;
      is_write_in  = is_write_ff;
      sector_in    = sector_ff;
      strobe_in    = 1'b0;
      hit_in       = hit_ff;
      entry_in     = entry_ff;
      fill_in      = fill_ff;
      wbv_in       = wbv_ff;
      wbs_in       = wbs_ff;
      last_in      = last_ff;
      wide         = '0;

      if (cmd.load) begin
         is_write_in  = (req_kind == sccr_pkg::KIND_WRITE);
         sector_in    = req_sector;
         inv_found_in = 1'b0;
      end
      if (cmd.idx_clr) begin
         idx_in = '0;
      end
      if (cmd.idx_inc) begin
         idx_in = idx_ff + IDX_W'(1);
      end
      if (cmd.note_inv && !inv_found_ff) begin
         inv_found_in = 1'b1;
         inv_idx_in   = idx_ff;
      end
      if (cmd.set_hit) begin
         vic_in = idx_ff;
      end
      if (cmd.pick_inv) begin
         vic_in = inv_idx_ff;
      end
      if (cmd.pick_hand) begin
         vic_in = hand_ff;
      end
      // Clock sweep: clear the reference bit and move the hand on.
      if (cmd.hand_step) begin
         ref_in[hand_ff] = 1'b0;
         hand_in = (hand_ff == IDX_LAST) ? '0 : hand_ff + IDX_W'(1);
      end

      if (cmd.emit_hit) begin
         wide              = {{sccr_pkg::ENTRY_W{1'b0}}, vic_ff};
         ref_in[vic_ff]    = 1'b1;
         if (is_write_ff) begin
            dirty_in[vic_ff] = 1'b1;
         end
         strobe_in = 1'b1;
         hit_in    = 1'b1;
         entry_in  = wide[sccr_pkg::ENTRY_W-1:0];
         fill_in   = 1'b0;
         wbv_in    = 1'b0;
         wbs_in    = '0;
         last_in   = 1'b1;
      end
      // Miss: the old tag is read back for a dirty victim's writeback.
      if (cmd.emit_miss) begin
         wide             = {{sccr_pkg::ENTRY_W{1'b0}}, vic_ff};
         valid_in[vic_ff] = 1'b1;
         dirty_in[vic_ff] = is_write_ff;
         ref_in[vic_ff]   = 1'b1;
         strobe_in = 1'b1;
         hit_in    = 1'b0;
         entry_in  = wide[sccr_pkg::ENTRY_W-1:0];
         fill_in   = 1'b1;
         wbv_in    = vic_vd;
         wbs_in    = vic_vd ? ram_rd_data : '0;
         last_in   = 1'b1;
      end
      if (cmd.emit_empty) begin
         strobe_in = 1'b1;
         hit_in    = 1'b0;
         entry_in  = '0;
         fill_in   = 1'b0;
         wbv_in    = 1'b0;
         wbs_in    = '0;
         last_in   = 1'b1;
      end
      // Flush: report the entry at the scan index and clean it.
      if (cmd.emit_flush) begin
         wide             = {{sccr_pkg::ENTRY_W{1'b0}}, idx_ff};
         dirty_in[idx_ff] = 1'b0;
         strobe_in = 1'b1;
         hit_in    = 1'b0;
         entry_in  = wide[sccr_pkg::ENTRY_W-1:0];
         fill_in   = 1'b0;
         wbv_in    = 1'b1;
         wbs_in    = ram_rd_data;
         last_in   = !(|(vd & ~idx_onehot));
      end
   end

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         dirty_ff     <= '0;
         ref_ff       <= '0;
         hand_ff      <= '0;
         idx_ff       <= '0;
         inv_found_ff <= 1'b0;
         strobe_ff    <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         dirty_ff     <= dirty_in;
         ref_ff       <= ref_in;
         hand_ff      <= hand_in;
         idx_ff       <= idx_in;
         inv_found_ff <= inv_found_in;
         strobe_ff    <= strobe_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      vic_ff      <= vic_in;
      inv_idx_ff  <= inv_idx_in;
      is_write_ff <= is_write_in;
      sector_ff   <= sector_in;
      hit_ff      <= hit_in;
      entry_ff    <= entry_in;
      fill_ff     <= fill_in;
      wbv_ff      <= wbv_in;
      wbs_ff      <= wbs_in;
      last_ff     <= last_in;
   end

   assign rsp_strobe           = strobe_ff;
   assign rsp_hit              = hit_ff;
   assign rsp_entry            = entry_ff;
   assign rsp_fill_needed      = fill_ff;
   assign rsp_writeback_valid  = wbv_ff;
   assign rsp_writeback_sector = wbs_ff;
   assign rsp_last             = last_ff;

endmodule

// ----- rtl/core/sccr_ctrl.sv -----
module sccr_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [sccr_pkg::KIND_W-1:0]  req_kind,
   input  sccr_pkg::status_type         status,
   output sccr_pkg::cmd_type            cmd,
   output logic                         busy
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOOK_RD,
      ST_LOOK_CMP,
      ST_MISS,
      ST_SWEEP,
      ST_VIC_RD,
      ST_VIC_WR,
      ST_HIT,
      ST_FL_START,
      ST_FL_SCAN,
      ST_FL_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load    = 1'b1;
               cmd.idx_clr = 1'b1;
               case (req_kind)
                  sccr_pkg::KIND_READ:  state_in = ST_LOOK_RD;
                  sccr_pkg::KIND_WRITE: state_in = ST_LOOK_RD;
                  sccr_pkg::KIND_FLUSH: state_in = ST_FL_START;
                  default:              state_in = ST_IDLE;
               endcase
            end
         end
         // Tag search, one entry at a time; invalid entries are skipped without a tag read.
         ST_LOOK_RD: begin
            if (status.idx_valid) begin
               cmd.rd_idx = 1'b1;
               state_in   = ST_LOOK_CMP;
            end else begin
               cmd.note_inv = 1'b1;
               if (status.idx_last) begin
                  state_in = ST_MISS;
               end else begin
                  cmd.idx_inc = 1'b1;
               end
            end
         end
         ST_LOOK_CMP: begin
            if (status.tag_match) begin
               cmd.set_hit = 1'b1;
               state_in    = ST_HIT;
            end else if (status.idx_last) begin
               state_in = ST_MISS;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_LOOK_RD;
            end
         end
         ST_MISS: begin
            if (status.inv_found) begin
               cmd.pick_inv = 1'b1;
               state_in     = ST_VIC_RD;
            end else begin
               state_in = ST_SWEEP;
            end
         end
         // Clock sweep until a clear reference bit is found.
         ST_SWEEP: begin
            if (status.hand_ref) begin
               cmd.hand_step = 1'b1;
            end else begin
               cmd.pick_hand = 1'b1;
               state_in      = ST_VIC_RD;
            end
         end
         ST_VIC_RD: begin
            cmd.rd_vic = 1'b1;
            state_in   = ST_VIC_WR;
         end
         ST_VIC_WR: begin
            cmd.emit_miss = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_HIT: begin
            cmd.emit_hit = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_FL_START: begin
            if (status.any_vd) begin
               state_in = ST_FL_SCAN;
            end else begin
               cmd.emit_empty = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         // Flush walks up from entry zero to each dirty entry.
         ST_FL_SCAN: begin
            if (status.idx_vd) begin
               cmd.rd_idx = 1'b1;
               state_in   = ST_FL_EMIT;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_FL_EMIT: begin
            cmd.emit_flush = 1'b1;
            if (status.more_vd) begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_FL_SCAN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      busy_in = (state_in != ST_IDLE);
   end

   // State and registered busy.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   assign busy = busy_ff;

endmodule

// ----- rtl/core/sector_cache_clock_replacement.sv -----
// Tag and clock-replacement controller for a fully associative write-back
// sector cache. A request is taken when start is high and busy is low; each
// result appears for exactly one cycle with rsp_strobe high and cannot be
// held off, so the receiver must take it then. Read and write requests
// search the tag memory one entry at a time through its single read port,
// reading the tag only of valid entries; a miss with every entry valid
// adds a clock sweep to choose the victim. A flush passes over clean
// entries and reports each dirty one, giving one result per dirty entry
// in ascending order, or a single empty result when no entry is dirty.
// The unused request kind is taken and produces no result.
module sector_cache_clock_replacement #(
   parameter int ENTRIES = sccr_pkg::ENTRIES_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [sccr_pkg::KIND_W-1:0]    req_kind,
   input  logic [sccr_pkg::SECTOR_W-1:0]  req_sector,
   output logic                           rsp_strobe,
   output logic                           rsp_hit,
   output logic [sccr_pkg::ENTRY_W-1:0]   rsp_entry,
   output logic                           rsp_fill_needed,
   output logic                           rsp_writeback_valid,
   output logic [sccr_pkg::SECTOR_W-1:0]  rsp_writeback_sector,
   output logic                           rsp_last
);

   sccr_pkg::cmd_type    cmd;
   sccr_pkg::status_type status;
   logic                 start_ok;

   // Requests arriving while busy are not taken.
   assign start_ok = start & ~busy;

   sccr_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start_ok),
      .req_kind(req_kind),
      .status  (status),
      .cmd     (cmd),
      .busy    (busy)
   );

   sccr_datapath #(
      .ENTRIES(ENTRIES)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_kind            (req_kind),
      .req_sector          (req_sector),
      .rsp_strobe          (rsp_strobe),
      .rsp_hit             (rsp_hit),
      .rsp_entry           (rsp_entry),
      .rsp_fill_needed     (rsp_fill_needed),
      .rsp_writeback_valid (rsp_writeback_valid),
      .rsp_writeback_sector(rsp_writeback_sector),
      .rsp_last            (rsp_last)
   );

endmodule
